FILE: sv/piecewise_parabolic_s_curve_macros.svh
// piecewise_parabolic_s_curve_macros.svh: assertion macros for the S-curve block.
// Expects clk and rst (synchronous, active high) in the scope of each use.
`ifndef PIECEWISE_PARABOLIC_S_CURVE_MACROS_SVH
`define PIECEWISE_PARABOLIC_S_CURVE_MACROS_SVH

// same-cycle implication, masked during reset
`define PPSC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked during reset
`define PPSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/ppsc_pkg.sv
// ppsc_pkg: shared types, constants and helpers for the piecewise parabolic S curve.
// No dependencies; imported by ppsc_div_step and piecewise_parabolic_s_curve.
`default_nettype none

package ppsc_pkg;

  localparam int SAMPLE_W      = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_IDX_W     = 2;

  // breakpoint reset values, Q16.16
  localparam logic signed [SAMPLE_W-1:0] START_X_RST  = 32'sd0;
  localparam logic signed [SAMPLE_W-1:0] CENTER_X_RST = 32'sd32768;
  localparam logic signed [SAMPLE_W-1:0] END_X_RST    = 32'sd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_X       = 2'd0,
    REG_CENTER_X      = 2'd1,
    REG_END_X         = 2'd2,
    REG_POSITIVE_AXIS = 2'd3
  } ppsc_reg_t;

  // which piece of the curve a sample falls on
  typedef enum logic [1:0] {
    CLS_ZERO  = 2'd0,
    CLS_ONE   = 2'd1,
    CLS_LOWER = 2'd2,
    CLS_UPPER = 2'd3
  } ppsc_cls_t;

  // sideband carried alongside the divider
  typedef struct packed {
    ppsc_cls_t cls;
    logic      sat;
  } ppsc_side_t;

  // magnitude of a breakpoint difference (always below 2^32)
  function automatic logic [SAMPLE_W-1:0] mag33(input logic signed [SAMPLE_W:0] d);
    logic signed [SAMPLE_W:0] neg;
    neg = -d;
    return d[SAMPLE_W] ? neg[SAMPLE_W-1:0] : d[SAMPLE_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: sv/ppsc_div_step.sv
// ppsc_div_step: one registered restoring-division step (one quotient bit).
// Depends on ppsc_pkg.
`default_nettype none

module ppsc_div_step #(
  parameter int FRAC_BITS = ppsc_pkg::FRAC_BITS_DEF,
  parameter int BIT       = 0
) (
  input  logic                                      clk,
  input  logic                                      en,
  input  logic [2*ppsc_pkg::SAMPLE_W+FRAC_BITS:0]   rem_in,
  input  logic [2*ppsc_pkg::SAMPLE_W-1:0]           den_in,
  input  logic [FRAC_BITS+1:0]                      q_in,
  input  ppsc_pkg::ppsc_side_t                      side_in,
  output logic [2*ppsc_pkg::SAMPLE_W+FRAC_BITS:0]   rem,
  output logic [2*ppsc_pkg::SAMPLE_W-1:0]           den,
  output logic [FRAC_BITS+1:0]                      q,
  output ppsc_pkg::ppsc_side_t                      side
);
  import ppsc_pkg::*;

  localparam int RemW = 2 * SAMPLE_W + FRAC_BITS + 1;

  logic [RemW-1:0]        trial;
  logic                   fits;
  logic [RemW-1:0]        rem_next;
  logic [FRAC_BITS+1:0]   q_next;

  always_comb begin
    trial    = RemW'(den_in) << BIT;
    fits     = (rem_in >= trial);
    rem_next = fits ? (rem_in - trial) : rem_in;
    q_next   = q_in;
    q_next[BIT] = fits;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem  <= rem_next;
      den  <= den_in;
      q    <= q_next;
      side <= side_in;
    end
  end

endmodule

`default_nettype wire

FILE: sv/piecewise_parabolic_s_curve.sv
// piecewise_parabolic_s_curve: two-parabola smoothstep over signed Q16.16 samples.
// Depends on ppsc_pkg, ppsc_div_step and piecewise_parabolic_s_curve_macros.svh.
//
// Usage:
//  - Samples enter on sample_valid/sample_stall; a transaction completes on a
//    rising edge with sample_valid high and sample_stall low. Results leave on
//    curve_valid/curve_stall the same way, one result per sample, in order.
//  - Breakpoints and direction go on the cfg_valid/cfg_ready channel (cfg_ready
//    always high), by the user only while no sample is in flight (not enforced).
//  - Throughput: one sample per clock while sample_stall is low. The path to
//    curve_valid runs through the three front-end stages (differences, piece
//    select, squares), then the FRAC_BITS+2 registered restoring-division
//    stages, then the output register.
//  - Reset clears all valid bits and loads the breakpoints with 0, 0.5, 1.0
//    in Q16.16, ascending direction.
//  - When the receiver stalls, the result holds in the output register and
//    one more result lands in a skid register; only then does sample_stall
//    rise and the whole pipeline freeze. Nothing is dropped or repeated.
`default_nettype none

`include "piecewise_parabolic_s_curve_macros.svh"

module piecewise_parabolic_s_curve #(
  parameter int FRAC_BITS = ppsc_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // sample channel
  input  logic                                  sample_valid,
  output logic                                  sample_stall,
  input  logic signed [ppsc_pkg::SAMPLE_W-1:0]  sample_x,
  // result channel
  output logic                                  curve_valid,
  input  logic                                  curve_stall,
  output logic [FRAC_BITS:0]                    curve_value,
  // configuration write channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ppsc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ppsc_pkg::SAMPLE_W-1:0]         cfg_data
);
  import ppsc_pkg::*;

  localparam int QW    = FRAC_BITS + 2;          // quotient bits, F+1 down to 0
  localparam int RemW  = 2 * SAMPLE_W + FRAC_BITS + 1;
  localparam int SqW   = 2 * SAMPLE_W;
  localparam int PipeN = QW + 3;                 // front end + divider stages
  localparam logic [QW-1:0] OneQ = {2'b01, {FRAC_BITS{1'b0}}};
  localparam logic [FRAC_BITS:0] OneOut = {1'b1, {FRAC_BITS{1'b0}}};

  // ---------------------------------------------------------------------------
  // Configuration registers, read directly by stages 1 and 2. The user must keep
  // them stable while samples are in flight; the block does not enforce this.
  // ---------------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] start_x;
  logic signed [SAMPLE_W-1:0] center_x;
  logic signed [SAMPLE_W-1:0] end_x;
  logic                       positive_axis;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x       <= START_X_RST;
      center_x      <= CENTER_X_RST;
      end_x         <= END_X_RST;
      positive_axis <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (ppsc_reg_t'(cfg_index))
        REG_START_X:       start_x       <= cfg_data;
        REG_CENTER_X:      center_x      <= cfg_data;
        REG_END_X:         end_x         <= cfg_data;
        REG_POSITIVE_AXIS: positive_axis <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control: the whole pipeline advances together unless the skid
  // register holds a result. Valid bits shift with the data.
  // ---------------------------------------------------------------------------
  logic             advance;
  logic [PipeN-1:0] pipe_valid;
  logic             skid_valid;
  logic [FRAC_BITS:0] skid_value;

  assign advance      = !skid_valid;
  assign sample_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= '0;
    end else if (advance) begin
      pipe_valid <= {pipe_valid[PipeN-2:0], sample_valid};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: exact 33-bit differences.
  // ---------------------------------------------------------------------------
  logic signed [SAMPLE_W:0] s1_xz, s1_xo, s1_xm, s1_mz, s1_om;

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_xz <= {sample_x[SAMPLE_W-1], sample_x} - {start_x[SAMPLE_W-1], start_x};
      s1_xo <= {sample_x[SAMPLE_W-1], sample_x} - {end_x[SAMPLE_W-1], end_x};
      s1_xm <= {sample_x[SAMPLE_W-1], sample_x} - {center_x[SAMPLE_W-1], center_x};
      s1_mz <= {center_x[SAMPLE_W-1], center_x} - {start_x[SAMPLE_W-1], start_x};
      s1_om <= {end_x[SAMPLE_W-1], end_x} - {center_x[SAMPLE_W-1], center_x};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: piece select (one test first, then zero, then which parabola),
  // with comparisons mirrored in descending mode; pick the arc operands.
  // ---------------------------------------------------------------------------
  logic      hit_one, hit_zero, on_lower;
  ppsc_cls_t cls_next;
  logic [SAMPLE_W-1:0] s2_a, s2_b;
  ppsc_cls_t           s2_cls;

  always_comb begin
    if (positive_axis) begin
      hit_one  = !s1_xo[SAMPLE_W];
      hit_zero = s1_xz[SAMPLE_W] || (s1_xz == '0);
      on_lower = s1_xm[SAMPLE_W];
    end else begin
      hit_one  = s1_xo[SAMPLE_W] || (s1_xo == '0);
      hit_zero = !s1_xz[SAMPLE_W];
      on_lower = !s1_xm[SAMPLE_W] && (s1_xm != '0);
    end
    if (hit_one) begin
      cls_next = CLS_ONE;
    end else if (hit_zero) begin
      cls_next = CLS_ZERO;
    end else if (on_lower) begin
      cls_next = CLS_LOWER;
    end else begin
      cls_next = CLS_UPPER;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_cls <= cls_next;
      s2_a   <= on_lower ? mag33(s1_xz) : mag33(s1_xo);
      s2_b   <= on_lower ? mag33(s1_mz) : mag33(s1_om);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: squares, plus the saturation guard (zero-width segment or a
  // quotient of two or more).
  // ---------------------------------------------------------------------------
  logic [SqW-1:0] s3_sq_a, s3_sq_b;
  ppsc_side_t     s3_side;

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_sq_a <= SqW'(s2_a) * SqW'(s2_a);
      s3_sq_b <= SqW'(s2_b) * SqW'(s2_b);
      s3_side <= '{cls: s2_cls,
                   sat: (s2_b == '0) || ({1'b0, s2_a} >= {s2_b, 1'b0})};
    end
  end

  // ---------------------------------------------------------------------------
  // Divider: floor(a^2 * 2^(F-1) / b^2), one quotient bit per stage, MSB first.
  // ---------------------------------------------------------------------------
  logic [RemW-1:0] div_rem  [QW+1];
  logic [SqW-1:0]  div_den  [QW+1];
  logic [QW-1:0]   div_q    [QW+1];
  ppsc_side_t      div_side [QW+1];

  assign div_rem[0]  = RemW'(s3_sq_a) << (FRAC_BITS - 1);
  assign div_den[0]  = s3_sq_b;
  assign div_q[0]    = '0;
  assign div_side[0] = s3_side;

  for (genvar j = 0; j < QW; j++) begin : g_div
    ppsc_div_step #(
      .FRAC_BITS (FRAC_BITS),
      .BIT       (QW - 1 - j)
    ) u_step (
      .clk     (clk),
      .en      (advance),
      .rem_in  (div_rem[j]),
      .den_in  (div_den[j]),
      .q_in    (div_q[j]),
      .side_in (div_side[j]),
      .rem     (div_rem[j+1]),
      .den     (div_den[j+1]),
      .q       (div_q[j+1]),
      .side    (div_side[j+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Output: clamp the arc, map the piece, then output register + skid.
  // ---------------------------------------------------------------------------
  logic [QW-1:0]      q_fin, lower_v, upper_v, res_q;
  ppsc_side_t         side_fin;
  logic [FRAC_BITS:0] res;

  always_comb begin
    q_fin    = div_q[QW];
    side_fin = div_side[QW];
    lower_v  = (side_fin.sat || (q_fin > OneQ)) ? OneQ : q_fin;
    upper_v  = (side_fin.sat || (q_fin >= OneQ)) ? '0 : (OneQ - q_fin);
    case (side_fin.cls)
      CLS_ONE:   res_q = OneQ;
      CLS_ZERO:  res_q = '0;
      CLS_LOWER: res_q = lower_v;
      CLS_UPPER: res_q = upper_v;
      default:   res_q = '0;
    endcase
    res = res_q[FRAC_BITS:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_valid <= 1'b0;
      skid_valid  <= 1'b0;
    end else if (skid_valid) begin
      // pipeline frozen; drain the skid once the head is taken
      if (!curve_stall) begin
        curve_value <= skid_value;
        skid_valid  <= 1'b0;
      end
    end else if (pipe_valid[PipeN-1]) begin
      if (!curve_valid || !curve_stall) begin
        curve_valid <= 1'b1;
        curve_value <= res;
      end else begin
        skid_valid <= 1'b1;
        skid_value <= res;
      end
    end else if (!curve_stall) begin
      curve_valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `PPSC_ASSERT_SAME(a_value_range, curve_valid, curve_value <= OneOut, "curve_value above 1.0")
  `PPSC_ASSERT_SAME(a_skid_behind_head, sample_stall, curve_valid, "skid full without a head result")
  `PPSC_ASSERT_NEXT(a_accept_enters, sample_valid && !sample_stall, pipe_valid[0], "accepted sample lost at entry")

endmodule

`default_nettype wire
